// ----- hw/rtl/hame_pkg.sv -----
// Package: shared types and constants for the mutation enumerator.
`default_nettype none
package hame_pkg;

	localparam int POSITION_BITS = 16;
	localparam int BEGIN_W       = 16;
	localparam int END_W         = 17;
	localparam int CMP_W         = (POSITION_BITS + 1 > END_W) ? POSITION_BITS + 1 : END_W;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 17;
	localparam int NUM_SLOTS     = 9;
	localparam int SLOT_W        = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BEGIN = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END   = CFG_INDEX_W'(1);

	localparam logic [1:0] KIND_SUB = 2'd0;
	localparam logic [1:0] KIND_INS = 2'd1;
	localparam logic [1:0] KIND_DEL = 2'd2;

	localparam logic [SLOT_W-1:0] SLOT_INS0 = SLOT_W'(4);
	localparam logic [SLOT_W-1:0] SLOT_DEL  = SLOT_W'(8);

	typedef struct packed {
		logic [1:0] template_base;
		logic       first_base;
	} in_item_t;

	typedef struct packed {
		logic [1:0]               mutation_kind;
		logic [POSITION_BITS-1:0] mutation_position;
		logic [1:0]               new_base;
		logic                     last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [1:0]               base;
		logic [1:0]               prev;
		logic                     have_prev;
		logic [POSITION_BITS-1:0] pos;
	} desc_t;

endpackage
`default_nettype wire

// ----- hw/rtl/homopolymer_aware_mutation_enumerator.sv -----
// Top level: single-base mutation enumerator with homopolymer-aware indels.
// Bases are taken one per transaction and at most one per cycle while the
// two-entry queue between front and back ends has room; a base outside
// [window_begin, window_end) is accepted but not queued and gives no
// results. A base inside the window gives six to eight result transactions,
// one per cycle from the output register while out_ready is held high, so
// with a steady stream the back end's slot walker sets the pace. A base
// passes through the queue and slot mask register to the output register.
// Configuration writes are always taken and must be made while the block is idle.
`default_nettype none
module homopolymer_aware_mutation_enumerator
	import hame_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire in_item_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output out_item_t                   out_data
);

	logic  push;
	logic  full;
	logic  not_empty;
	logic  pop;
	desc_t push_desc;
	desc_t pop_desc;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;

	hame_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (in_valid && in_ready),
		.item      (in_data),
		.push      (push),
		.desc      (push_desc)
	);

	hame_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_desc),
		.full      (full),
		.not_empty (not_empty),
		.pop       (pop),
		.pop_data  (pop_desc)
	);

	hame_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (not_empty),
		.desc       (pop_desc),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/hame_front.sv -----
// Front end: window registers, position and previous-base tracking, classification.
`default_nettype none
module hame_front
	import hame_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   accept,
	input  wire in_item_t               item,
	output logic                        push,
	output desc_t                       desc
);

	logic [BEGIN_W-1:0]       window_begin_q;
	logic [END_W-1:0]         window_end_q;
	logic [1:0]               prev_base_q;
	logic                     prev_present_q;
	logic [POSITION_BITS:0]   pos_count_q;
	logic [POSITION_BITS:0]   pos;
	logic                     have_prev;
	logic                     in_window;

	always_comb begin
		pos       = item.first_base ? '0 : pos_count_q;
		have_prev = item.first_base ? 1'b0 : prev_present_q;
		in_window = !pos[POSITION_BITS]
			&& (CMP_W'(pos) >= CMP_W'(window_begin_q))
			&& (CMP_W'(pos) < CMP_W'(window_end_q));
	end

	assign push           = accept && in_window;
	assign desc.base      = item.template_base;
	assign desc.prev      = prev_base_q;
	assign desc.have_prev = have_prev;
	assign desc.pos       = pos[POSITION_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_begin_q <= '0;
			window_end_q   <= END_W'(65536);
			prev_base_q    <= '0;
			prev_present_q <= 1'b0;
			pos_count_q    <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_WINDOW_BEGIN: window_begin_q <= cfg_data[BEGIN_W-1:0];
					REG_WINDOW_END:   window_end_q   <= cfg_data[END_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				prev_base_q    <= item.template_base;
				prev_present_q <= 1'b1;
				// saturates at 2^POSITION_BITS
				pos_count_q    <= pos[POSITION_BITS] ? pos : pos + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/hame_fifo.sv -----
// Two-entry queue of classified bases between front and back ends.
`default_nettype none
module hame_fifo
	import hame_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_data,
	output logic       full,
	output logic       not_empty,
	input  wire logic  pop,
	output desc_t      pop_data
);

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/hame_back.sv -----
// Back end: walks the mutation slots of one base and drives the result register.
`default_nettype none
module hame_back
	import hame_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      desc_valid,
	input  wire desc_t     desc,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	logic [NUM_SLOTS-1:0]     mask_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic [NUM_SLOTS-1:0]     new_mask;
	logic [NUM_SLOTS-1:0]     mask_rest;
	logic [SLOT_W-1:0]        slot;
	logic                     advance;
	out_item_t                next_out;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			new_mask[b]     = desc.base != 2'(b);
			new_mask[b + 4] = !desc.have_prev || (desc.prev != 2'(b));
		end
		new_mask[NUM_SLOTS-1] = !desc.have_prev || (desc.base != desc.prev);

		slot = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				slot = SLOT_W'(i);
			end
		end

		mask_rest = mask_q & ~(NUM_SLOTS'(1) << slot);
		advance   = (mask_q != '0) && (!out_valid_q || out_ready);
		pop       = desc_valid && ((mask_q == '0) || (advance && (mask_rest == '0)));

		if (slot == SLOT_DEL) begin
			next_out.mutation_kind = KIND_DEL;
			next_out.new_base      = 2'd0;
		end else if (slot >= SLOT_INS0) begin
			next_out.mutation_kind = KIND_INS;
			next_out.new_base      = slot[1:0];
		end else begin
			next_out.mutation_kind = KIND_SUB;
			next_out.new_base      = slot[1:0];
		end
		next_out.mutation_position = pos_q;
		next_out.last_of_run       = mask_rest == '0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= next_out;
		end
		if (pop) begin
			pos_q <= desc.pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= new_mask;
			end else if (advance) begin
				mask_q <= mask_rest;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/hame_checker.sv -----
// Port-level checker for the mutation enumerator, bound to the top level.
`default_nettype none
module hame_checker
	import hame_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire out_item_t              out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_del_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.mutation_kind == KIND_DEL) |-> out_data.last_of_run)
		else $error("deletion not last of run");

	a_del_base: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.mutation_kind == KIND_DEL) |-> out_data.new_base == 2'd0)
		else $error("deletion with non-zero base");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_of_run |=>
			out_valid
			&& (out_data.mutation_position == $past(out_data.mutation_position)))
		else $error("run broken before its last transaction");

endmodule

bind homopolymer_aware_mutation_enumerator hame_checker u_hame_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_homopolymer_aware_mutation_enumerator.sv -----
// Testbench for the mutation enumerator: directed and random bases checked against a predictor.
`default_nettype none
module tb_homopolymer_aware_mutation_enumerator;
	import hame_pkg::*;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

	localparam logic [POSITION_BITS:0] POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};
	localparam int SETTLE_CYCLES    = 12;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int RANDOM_TEMPLATES = 6;
	localparam int TEMPLATE_LEN     = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	in_item_t               in_data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_data;

	// predictor state
	logic [BEGIN_W-1:0]       win_begin = '0;
	logic [END_W-1:0]         win_end = END_W'(65536);
	logic [1:0]               prev_base = '0;
	logic                     prev_present = 1'b0;
	logic [POSITION_BITS:0]   pos_count = '0;

	in_item_t  base_queue[$];
	out_item_t mut_expected[$];
	out_item_t mut_head;
	int        bases_pending = 0;
	int        fail_count = 0;
	int        in_gap = 0;
	int        out_stall = 0;
	int        idle_cycles = 0;
	bit        steady = 1'b0;
	logic [1:0] last_gen = '0;

	homopolymer_aware_mutation_enumerator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic predict_mutations(input in_item_t it);
		out_item_t run[8];
		int n;
		logic [POSITION_BITS:0] p;
		logic hp;
		logic [1:0] pb;
		n = 0;
		if (it.first_base) begin
			pos_count = '0;
			prev_present = 1'b0;
		end
		p = pos_count;
		hp = prev_present;
		pb = prev_base;
		if (p < POS_LIMIT && p >= win_begin && p < win_end) begin
			for (int b = 0; b < 4; b++) begin
				if (2'(b) != it.template_base) begin
					run[n] = '{KIND_SUB, p[POSITION_BITS-1:0], 2'(b), 1'b0};
					n++;
				end
			end
			for (int b = 0; b < 4; b++) begin
				if (!hp || 2'(b) != pb) begin
					run[n] = '{KIND_INS, p[POSITION_BITS-1:0], 2'(b), 1'b0};
					n++;
				end
			end
			if (!hp || it.template_base != pb) begin
				run[n] = '{KIND_DEL, p[POSITION_BITS-1:0], 2'd0, 1'b0};
				n++;
			end
			for (int i = 0; i < n; i++) begin
				if (i == n - 1)
					run[i].last_of_run = 1'b1;
				mut_expected.insert(mut_expected.size(), run[i]);
			end
		end
		prev_base = it.template_base;
		prev_present = 1'b1;
		if (pos_count < POS_LIMIT)
			pos_count = pos_count + 1'b1;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// base driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_mutations(in_data);
				bases_pending--;
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (base_queue.size() != 0) begin
					in_data <= base_queue.pop_front();
					in_valid <= 1'b1;
					in_gap <= steady ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (mut_expected.size() == 0) begin
					$error("unexpected result transaction: kind %0d position %0d base %0d",
						out_data.mutation_kind, out_data.mutation_position, out_data.new_base);
					fail_count++;
				end else begin
					mut_head = mut_expected.pop_front();
					check_field("mutation_kind", mut_head.mutation_kind, out_data.mutation_kind);
					check_field("mutation_position", mut_head.mutation_position,
						out_data.mutation_position);
					check_field("new_base", mut_head.new_base, out_data.new_base);
					check_field("last_of_run", mut_head.last_of_run, out_data.last_of_run);
				end
			end
			if (out_stall != 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				out_stall <= pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	task automatic queue_base(input logic [1:0] b, input logic first);
		in_item_t it;
		it.template_base = b;
		it.first_base = first;
		base_queue.insert(base_queue.size(), it);
		bases_pending++;
		last_gen = b;
	endtask

	// mostly homopolymer-rich runs, with the odd stray restart
	task automatic queue_template(input int count);
		logic [1:0] b;
		queue_base(2'($urandom_range(0, 3)), 1'b1);
		for (int i = 1; i < count; i++) begin
			b = ($urandom_range(0, 9) < 4) ? last_gen : 2'($urandom_range(0, 3));
			queue_base(b, $urandom_range(0, 99) < 8);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WINDOW_BEGIN: win_begin = val[BEGIN_W-1:0];
			REG_WINDOW_END: win_end = val[END_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (bases_pending != 0 || mut_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int lo;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset window: restarts, homopolymer runs, every base
		queue_base(BASE_A, 1'b1);
		queue_base(BASE_A, 1'b0);
		queue_base(BASE_C, 1'b0);
		queue_base(BASE_C, 1'b0);
		queue_base(BASE_G, 1'b0);
		queue_base(BASE_T, 1'b0);
		queue_base(BASE_T, 1'b0);
		queue_base(BASE_A, 1'b0);
		queue_base(BASE_G, 1'b0);
		queue_base(BASE_G, 1'b0);
		queue_base(BASE_C, 1'b1);
		queue_base(BASE_C, 1'b1);
		queue_base(BASE_T, 1'b0);
		queue_base(BASE_A, 1'b0);
		wait_idle();

		write_reg(REG_WINDOW_BEGIN, CFG_DATA_W'(3));
		write_reg(REG_WINDOW_END, CFG_DATA_W'(6));
		queue_template(9);
		wait_idle();

		// empty, inverted and zero windows
		write_reg(REG_WINDOW_BEGIN, CFG_DATA_W'(5));
		write_reg(REG_WINDOW_END, CFG_DATA_W'(5));
		queue_template(8);
		wait_idle();
		write_reg(REG_WINDOW_BEGIN, CFG_DATA_W'(10));
		write_reg(REG_WINDOW_END, CFG_DATA_W'(3));
		queue_template(12);
		wait_idle();
		write_reg(REG_WINDOW_BEGIN, CFG_DATA_W'(0));
		write_reg(REG_WINDOW_END, CFG_DATA_W'(0));
		queue_template(3);
		wait_idle();

		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));

		// top bit of begin dropped, end past the counter limit, no gaps
		write_reg(REG_WINDOW_BEGIN, 17'h10002);
		write_reg(REG_WINDOW_END, 17'h1FFFF);
		steady = 1'b1;
		queue_template(10);
		wait_idle();
		steady = 1'b0;

		for (int t = 0; t < RANDOM_TEMPLATES; t++) begin
			case ($urandom_range(0, 3))
				0: begin
					write_reg(REG_WINDOW_BEGIN, CFG_DATA_W'(0));
					write_reg(REG_WINDOW_END, CFG_DATA_W'(65536));
				end
				3: begin
					lo = $urandom_range(0, 20);
					write_reg(REG_WINDOW_BEGIN, CFG_DATA_W'(lo));
					write_reg(REG_WINDOW_END, CFG_DATA_W'(lo - $urandom_range(0, 1)));
				end
				default: begin
					lo = $urandom_range(0, 8);
					write_reg(REG_WINDOW_BEGIN, CFG_DATA_W'(lo));
					write_reg(REG_WINDOW_END, CFG_DATA_W'(lo + $urandom_range(4, 30)));
				end
			endcase
			queue_template(TEMPLATE_LEN);
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
